/* design/lbr_pkg.sv */
// shared types and codes of the led blink and rgb pwm controller
// no dependencies; imported by lbr_blink_chan and the top level
package lbr_pkg;

	localparam int TIME_W  = 16;
	localparam int PHASE_W = TIME_W + 1;
	localparam int NUM_LED = 2;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_BLINK = 2'd1,
		FUNC_LEVEL = 2'd2,
		FUNC_RGB   = 2'd3
	} lbr_func_t;

	typedef struct packed {
		logic              tick;
		logic              start;
		logic              set_level;
		logic              level;
		logic [TIME_W-1:0] half_period;
		logic [TIME_W-1:0] duration;
	} lbr_chan_cmd_t;

	typedef struct packed {
		logic pin;
		logic steady;
		logic busy;
	} lbr_chan_stat_t;

endpackage

/* design/lbr_blink_chan.sv */
// blink timer of one led channel: elapsed and phase counters, steady level
// depends on lbr_pkg
module lbr_blink_chan (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  lbr_pkg::lbr_chan_cmd_t  cmd,
	output lbr_pkg::lbr_chan_stat_t stat_nxt
);
	import lbr_pkg::*;

	logic               busy_q, busy_d;
	logic               steady_q, steady_d;
	logic               pin_q, pin_d;
	logic [TIME_W-1:0]  elapsed_q, elapsed_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [TIME_W-1:0]  half_q, half_d;
	logic [TIME_W-1:0]  dur_q, dur_d;

	logic [TIME_W-1:0]  elapsed_inc;
	logic [PHASE_W-1:0] full;
	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] phase_wrap;

	assign elapsed_inc = (elapsed_q == {TIME_W{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign full        = {half_q, 1'b0};
	assign phase_inc   = phase_q + 1'b1;
	// phase tracks elapsed mod (2 * half period) one step per tick
	assign phase_wrap  = (phase_inc == full) ? '0 : phase_inc;

	always_comb begin
		busy_d    = busy_q;
		steady_d  = steady_q;
		pin_d     = pin_q;
		elapsed_d = elapsed_q;
		phase_d   = phase_q;
		half_d    = half_q;
		dur_d     = dur_q;
		if (en) begin
			if (cmd.tick && busy_q) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= dur_q) begin
					busy_d = 1'b0;
					pin_d  = steady_q;
				end else if (full == '0) begin
					phase_d = '0;
					pin_d   = 1'b0;
				end else begin
					phase_d = phase_wrap;
					pin_d   = (phase_wrap < {1'b0, half_q});
				end
			end
			if (cmd.start) begin
				half_d    = cmd.half_period;
				dur_d     = cmd.duration;
				elapsed_d = '0;
				phase_d   = '0;
				busy_d    = 1'b1;
			end
			if (cmd.set_level) begin
				steady_d = cmd.level;
				if (!busy_q) begin
					pin_d = cmd.level;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			steady_q  <= 1'b0;
			pin_q     <= 1'b0;
			elapsed_q <= '0;
			phase_q   <= '0;
			half_q    <= '0;
			dur_q     <= '0;
		end else begin
			busy_q    <= busy_d;
			steady_q  <= steady_d;
			pin_q     <= pin_d;
			elapsed_q <= elapsed_d;
			phase_q   <= phase_d;
			half_q    <= half_d;
			dur_q     <= dur_d;
		end
	end

	assign stat_nxt.pin    = pin_d;
	assign stat_nxt.steady = steady_d;
	assign stat_nxt.busy   = busy_d;

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && cmd.start) |=> (busy_q && elapsed_q == '0 && phase_q == '0))
		else $error("blink start did not load a clean timer");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (phase_q < full || half_q == '0))
		else $error("blink phase left its period");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(pin_q) && $stable(busy_q) && $stable(elapsed_q)))
		else $error("channel state moved without a request");

endmodule

/* design/led_blink_and_rgb_pwm_controller_unit.sv */
// Two led blink channels and one rgb pwm colour stage behind stream ports.
// Every accepted request (a 1 ms tick, a blink start, a steady level write or
// an rgb write) updates the state and yields one result in the next cycle,
// carrying all pin, pwm and readback values, held in the result register; a
// request can be taken every cycle while the result register is free or being
// drained. The pwm duty is floor(v * PWM_FULL_SCALE / 255) kept to 10 bits,
// computed by a constant reciprocal multiply when the colour is written.
// depends on lbr_pkg and lbr_blink_chan
module led_blink_and_rgb_pwm_controller_unit #(
	parameter int PWM_FULL_SCALE = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// channel[1:0], half_period_ms[17:2], blink_len_ms[33:18], level[34],
	// red_in[50:35], green_in[66:51], blue_in[82:67], zero fill
	input  logic [87:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// led_a_pin[0], led_b_pin[1], led_a_steady[2], led_b_steady[3],
	// blink_a_busy[4], blink_b_busy[5], red_pwm[15:6], green_pwm[25:16],
	// blue_pwm[35:26], red_now[43:36], green_now[51:44], blue_now[59:52], zero fill
	output logic [63:0] m_axis_tdata
);
	import lbr_pkg::*;

	// 2^32 mod 255 is 1, so this reciprocal is exact for products below 2^24
	localparam logic [63:0] RECIP = 64'd16843010;
	localparam logic [63:0] MULT  = 64'(PWM_FULL_SCALE) * RECIP;

	function automatic logic [7:0] clamp_colour(input logic [15:0] raw);
		logic [7:0] v;
		if (raw[15]) begin
			v = 8'd0;
		end else if (raw[14:8] != '0) begin
			v = 8'd255;
		end else begin
			v = raw[7:0];
		end
		return v;
	endfunction

	function automatic logic [9:0] scale_colour(input logic [7:0] v);
		logic [71:0] prod;
		prod = 72'(v) * 72'(MULT);
		return prod[41:32];
	endfunction

	logic              accept;
	lbr_func_t         func;
	logic              chan_ok;
	logic [1:0]        chan_en;
	lbr_chan_cmd_t     cmd [NUM_LED];
	lbr_chan_stat_t    stat [NUM_LED];

	logic [7:0]        colour_q [3];
	logic [9:0]        pwm_q [3];
	logic [7:0]        colour_d [3];
	logic [9:0]        pwm_d [3];

	logic              res_valid_q;
	logic [63:0]       res_data_q;

	assign s_axis_tready = !res_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign func          = lbr_func_t'(s_axis_tuser);
	assign chan_ok       = !s_axis_tdata[1];
	assign chan_en[0]    = chan_ok && !s_axis_tdata[0];
	assign chan_en[1]    = chan_ok && s_axis_tdata[0];

	for (genvar c = 0; c < NUM_LED; c++) begin : g_chan
		assign cmd[c].tick        = (func == FUNC_TICK);
		assign cmd[c].start       = (func == FUNC_BLINK) && chan_en[c];
		assign cmd[c].set_level   = (func == FUNC_LEVEL) && chan_en[c];
		assign cmd[c].level       = s_axis_tdata[34];
		assign cmd[c].half_period = s_axis_tdata[17:2];
		assign cmd[c].duration    = s_axis_tdata[33:18];

		lbr_blink_chan u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (accept),
			.cmd      (cmd[c]),
			.stat_nxt (stat[c])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			colour_d[i] = colour_q[i];
			pwm_d[i]    = pwm_q[i];
		end
		if (accept) begin
			unique case (func)
				FUNC_RGB: begin
					colour_d[0] = clamp_colour(s_axis_tdata[50:35]);
					colour_d[1] = clamp_colour(s_axis_tdata[66:51]);
					colour_d[2] = clamp_colour(s_axis_tdata[82:67]);
					for (int i = 0; i < 3; i++) begin
						pwm_d[i] = scale_colour(colour_d[i]);
					end
				end
				FUNC_TICK, FUNC_BLINK, FUNC_LEVEL: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				colour_q[i] <= '0;
				pwm_q[i]    <= '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				colour_q[i] <= colour_d[i];
				pwm_q[i]    <= pwm_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q <= {4'd0, colour_d[2], colour_d[1], colour_d[0],
				pwm_d[2], pwm_d[1], pwm_d[0],
				stat[1].busy, stat[0].busy, stat[1].steady, stat[0].steady,
				stat[1].pin, stat[0].pin};
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_data_q;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
		else $error("accepted request produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("request taken while result stalled");

	a_colour_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && func == FUNC_RGB) |=>
			($stable(colour_q[0]) && $stable(colour_q[1]) && $stable(colour_q[2])))
		else $error("colour changed without an rgb request");

endmodule
